[rtl/tsp_pkg.sv]
// Types, request codes and note ROM shared by the tone sequence player.
package tsp_pkg;

  localparam int MAX_NOTES = 4;
  localparam int NUM_SEQS  = 6;
  localparam int ROM_NOTES = 3;

  localparam logic [19:0] TICKS_PER_MS_RST = 20'd1000;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] seq_id;
  } tsp_in_t;

  typedef struct packed {
    logic [11:0] tone_freq;
    logic        playing;
    logic [1:0]  current_note;
  } tsp_out_t;

  typedef struct packed {
    logic [11:0] freq;
    logic [7:0]  dur;
    logic [7:0]  gap;
  } note_t;

  function automatic note_t rom_note(input logic [2:0] seq, input logic [1:0] idx);
    note_t n;
    n = '0;
    case ({seq, idx})
      {3'd0, 2'd0}: n = '{12'd2500, 8'd100, 8'd150};
      {3'd0, 2'd1}: n = '{12'd2500, 8'd100, 8'd0};
      {3'd1, 2'd0}: n = '{12'd2500, 8'd80, 8'd0};
      {3'd2, 2'd0}: n = '{12'd2500, 8'd80, 8'd80};
      {3'd2, 2'd1}: n = '{12'd2500, 8'd80, 8'd0};
      {3'd3, 2'd0}: n = '{12'd2700, 8'd50, 8'd0};
      {3'd4, 2'd0}: n = '{12'd2200, 8'd50, 8'd30};
      {3'd4, 2'd1}: n = '{12'd2200, 8'd50, 8'd40};
      {3'd4, 2'd2}: n = '{12'd2600, 8'd90, 8'd0};
      {3'd5, 2'd0}: n = '{12'd2700, 8'd160, 8'd60};
      {3'd5, 2'd1}: n = '{12'd2000, 8'd70, 8'd0};
      default:      n = '0;
    endcase
    return n;
  endfunction

  // Notes in a sequence, clamped to MAX_NOTES.
  function automatic logic [4:0] seq_len(input logic [2:0] seq);
    logic [4:0] len;
    case (seq)
      3'd0:    len = 5'd2;
      3'd1:    len = 5'd1;
      3'd2:    len = 5'd2;
      3'd3:    len = 5'd1;
      3'd4:    len = 5'd3;
      3'd5:    len = 5'd2;
      default: len = 5'd0;
    endcase
    if (len > 5'(MAX_NOTES)) len = 5'(MAX_NOTES);
    return len;
  endfunction

endpackage

[rtl/tone_sequence_player.sv]
// Tone sequence player: plays one of six fixed note sequences as a tone frequency.
// Each word is a tick, a start or a stop request and yields one result word with
// the tone frequency, a playing flag and the note index after that request. The
// block takes one word per clock unless the result register is stalled: a word
// lands in the input register, passes the combinational next-state logic (ms
// prescaler compare, note ROM lookup) and is written with the new state into the
// result register when that register is free; a stall holds it in the input register.
// ticks_per_ms resets to 1000; the user writes it through cfg_we/cfg_data only while
// no word is in flight, which the block itself does not enforce; a value of 0 acts as 1.
module tone_sequence_player
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tsp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tsp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data
);

  logic        in_full;
  tsp_in_t     in_word;
  logic        advance;
  logic [19:0] ticks_per_ms;
  tsp_out_t    core_result;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TICKS_PER_MS_RST;
    end else if (cfg_we) begin
      ticks_per_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word <= in_data;
    end
  end

  tsp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .word         (in_word),
    .ticks_per_ms (ticks_per_ms),
    .result       (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

endmodule

[rtl/tsp_core.sv]
// Player state and next-state logic: prescaler, note/gap timing, sequencing.
module tsp_core
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  tsp_in_t     word,
  input  logic [19:0] ticks_per_ms,
  output tsp_out_t    result
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  note_pos, note_pos_next;
  logic [2:0]  active_seq, active_seq_next;
  logic [19:0] sub_ms_count, sub_ms_count_next;
  logic [7:0]  elapsed_ms, elapsed_ms_next;
  logic [11:0] tone_now, tone_now_next;

  logic [20:0] sub_inc;
  logic        ms_wrap;
  logic [7:0]  el_tick;
  logic [4:0]  len_cur;
  logic [2:0]  nxt_pos;
  logic        nxt_ok;
  note_t       cur_note, nxt_note, start_note;
  logic        bad_pos;

  always_comb begin
    sub_inc    = {1'b0, sub_ms_count} + 21'd1;
    ms_wrap    = sub_inc >= {1'b0, ticks_per_ms};
    el_tick    = (ms_wrap && elapsed_ms != 8'hFF) ? elapsed_ms + 8'd1 : elapsed_ms;
    len_cur    = seq_len(active_seq);
    nxt_pos    = {1'b0, note_pos} + 3'd1;
    nxt_ok     = 5'(nxt_pos) < len_cur;
    cur_note   = rom_note(active_seq, note_pos);
    nxt_note   = rom_note(active_seq, nxt_pos[1:0]);
    start_note = rom_note(word.seq_id, 2'd0);
    bad_pos    = (phase != PH_NOTE && phase != PH_GAP)
              || 32'(active_seq) >= NUM_SEQS
              || 5'(note_pos) >= len_cur
              || 32'(note_pos) >= ROM_NOTES;

    phase_next        = phase;
    note_pos_next     = note_pos;
    active_seq_next   = active_seq;
    sub_ms_count_next = sub_ms_count;
    elapsed_ms_next   = elapsed_ms;
    tone_now_next     = tone_now;

    case (word.req_type)
      REQ_TICK: begin
        if (phase != PH_IDLE) begin
          if (bad_pos) begin
            phase_next        = PH_IDLE;
            tone_now_next     = '0;
            sub_ms_count_next = '0;
            elapsed_ms_next   = '0;
          end else begin
            sub_ms_count_next = ms_wrap ? 20'd0 : sub_inc[19:0];
            elapsed_ms_next   = el_tick;
            if ((phase == PH_NOTE && el_tick >= cur_note.dur)
                || (phase == PH_GAP && el_tick >= cur_note.gap)) begin
              tone_now_next = '0;
              if (phase == PH_NOTE && cur_note.gap != 8'd0) begin
                phase_next        = PH_GAP;
                sub_ms_count_next = '0;
                elapsed_ms_next   = '0;
              end else if (nxt_ok) begin
                phase_next        = PH_NOTE;
                note_pos_next     = nxt_pos[1:0];
                sub_ms_count_next = '0;
                elapsed_ms_next   = '0;
                tone_now_next     = nxt_note.freq;
              end else begin
                phase_next        = PH_IDLE;
                sub_ms_count_next = '0;
                elapsed_ms_next   = '0;
              end
            end
          end
        end
      end
      REQ_START: begin
        if (32'(word.seq_id) < NUM_SEQS) begin
          active_seq_next   = word.seq_id;
          note_pos_next     = 2'd0;
          phase_next        = PH_NOTE;
          sub_ms_count_next = '0;
          elapsed_ms_next   = '0;
          tone_now_next     = start_note.freq;
        end
      end
      REQ_STOP: begin
        phase_next        = PH_IDLE;
        tone_now_next     = '0;
        sub_ms_count_next = '0;
        elapsed_ms_next   = '0;
      end
      default: ;
    endcase

    result.tone_freq    = tone_now_next;
    result.playing      = phase_next != PH_IDLE;
    result.current_note = (phase_next != PH_IDLE) ? note_pos_next : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      note_pos     <= '0;
      active_seq   <= '0;
      sub_ms_count <= '0;
      elapsed_ms   <= '0;
      tone_now     <= '0;
    end else if (en) begin
      phase        <= phase_next;
      note_pos     <= note_pos_next;
      active_seq   <= active_seq_next;
      sub_ms_count <= sub_ms_count_next;
      elapsed_ms   <= elapsed_ms_next;
      tone_now     <= tone_now_next;
    end
  end

endmodule

[rtl/tsp_checker.sv]
// Port-level checks for the tone sequence player, bound to the top level.
module tsp_checker
  import tsp_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input tsp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_idle_note: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.playing |-> out_data.current_note == 2'd0)
    else $error("idle result shows a note index");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.playing |-> out_data.tone_freq == 12'd0)
    else $error("tone driven while idle");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for tone_sequence_player: directed requests, tick rate extremes, random sequences.
module testbench;
  import tsp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;

  typedef enum logic [1:0] {ST_IDLE, ST_TONE, ST_GAP} play_state_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tsp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tsp_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_data = '0;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int words_checked = 0;
  int errors = 0;
  int idle_cycles = 0;

  tsp_out_t expected_tones[$];
  tsp_out_t want;

  // Player state as seen by the predictor
  play_state_e st = ST_IDLE;
  logic [1:0]  note_idx = '0;
  logic [2:0]  seq_sel = '0;
  logic [19:0] ms_sub = '0;
  logic [7:0]  ms_cnt = '0;
  logic [11:0] tone_hz = '0;
  logic [19:0] tick_div = TICKS_PER_MS_RST;

  // Note table: frequency, duration and gap per sequence and note
  int note_hz[6][3] = '{'{2500, 2500, 0}, '{2500, 0, 0}, '{2500, 2500, 0},
                        '{2700, 0, 0}, '{2200, 2200, 2600}, '{2700, 2000, 0}};
  int note_ms[6][3] = '{'{100, 100, 0}, '{80, 0, 0}, '{80, 80, 0},
                        '{50, 0, 0}, '{50, 50, 90}, '{160, 70, 0}};
  int note_gap[6][3] = '{'{150, 0, 0}, '{0, 0, 0}, '{80, 0, 0},
                         '{0, 0, 0}, '{30, 40, 0}, '{60, 0, 0}};
  int seq_notes[6] = '{2, 1, 2, 1, 3, 2};

  tone_sequence_player uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void silence();
    st = ST_IDLE;
    tone_hz = '0;
    ms_sub = '0;
    ms_cnt = '0;
  endfunction

  function automatic void start_note(input logic [1:0] idx);
    note_idx = idx;
    st = ST_TONE;
    ms_sub = '0;
    ms_cnt = '0;
    tone_hz = 12'(note_hz[seq_sel][idx]);
  endfunction

  function automatic void next_note();
    if (int'(note_idx) + 1 < seq_notes[seq_sel]) start_note(note_idx + 2'd1);
    else silence();
  endfunction

  function automatic tsp_out_t apply_request(input tsp_in_t w);
    tsp_out_t r;
    case (w.req_type)
      REQ_TICK: if (st != ST_IDLE) begin
        // a divider of 0 rolls over on every tick, same as 1
        if ({1'b0, ms_sub} + 21'd1 >= {1'b0, tick_div}) begin
          ms_sub = '0;
          if (ms_cnt != 8'd255) ms_cnt = ms_cnt + 8'd1;
        end else ms_sub = ms_sub + 20'd1;
        if (st == ST_TONE) begin
          if (int'(ms_cnt) >= note_ms[seq_sel][note_idx]) begin
            tone_hz = '0;
            if (note_gap[seq_sel][note_idx] > 0) begin
              st = ST_GAP;
              ms_sub = '0;
              ms_cnt = '0;
            end else next_note();
          end
        end else if (int'(ms_cnt) >= note_gap[seq_sel][note_idx]) next_note();
      end
      REQ_START: if (int'(w.seq_id) < NUM_SEQS) begin
        seq_sel = w.seq_id;
        start_note(2'd0);
      end
      REQ_STOP: silence();
      default: ;
    endcase
    r.tone_freq = tone_hz;
    r.playing = (st != ST_IDLE);
    r.current_note = r.playing ? note_idx : 2'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Result checking first, then prediction of the word accepted at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_tones.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: %p", out_data));
        end else begin
          want = expected_tones.pop_front();
          if (out_data.tone_freq !== want.tone_freq)
            report_mismatch($sformatf("word %0d tone_freq %0d, expected %0d", words_checked,
                                      out_data.tone_freq, want.tone_freq));
          if (out_data.playing !== want.playing)
            report_mismatch($sformatf("word %0d playing %0b, expected %0b", words_checked,
                                      out_data.playing, want.playing));
          if (out_data.current_note !== want.current_note)
            report_mismatch($sformatf("word %0d current_note %0d, expected %0d", words_checked,
                                      out_data.current_note, want.current_note));
          words_checked++;
        end
      end
      if (in_valid && in_ready) expected_tones.push_back(apply_request(in_data));
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_tones.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [2:0] sid);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, seq_id: sid};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tones.size() != 0) @(posedge clk);
  endtask

  task automatic write_tick_div(input logic [19:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_div = v;
  endtask

  task automatic test_requests();
    int s;
    send_req(REQ_TICK, 3'd7);
    send_req(REQ_START, 3'd0);
    send_req(REQ_TICK, 3'd0);
    for (s = 1; s < NUM_SEQS; s++) send_req(REQ_START, 3'(s));
    send_req(REQ_TICK, 3'd5);
    send_req(REQ_START, 3'd6);
    send_req(REQ_START, 3'd7);
    send_req(REQ_UNUSED, 3'd2);
    send_req(REQ_STOP, 3'd1);
    send_req(REQ_TICK, 3'd4);
    send_req(REQ_STOP, 3'd0);
    send_req(REQ_UNUSED, 3'd7);
    send_req(REQ_START, 3'd4);
    send_req(REQ_START, 3'd4);
    send_req(REQ_STOP, 3'd3);
  endtask

  task automatic test_tick_rates();
    logic [19:0] rates[5] = '{20'd0, 20'hFFFFF, 20'd1000000, 20'd1, 20'd2};
    int i;
    for (i = 0; i < 5; i++) begin
      write_tick_div(rates[i]);
      send_req(REQ_START, 3'($urandom_range(5)));
      repeat (3) send_req(REQ_TICK, 3'($urandom_range(7)));
    end
  endtask

  // One start, then enough ticks to run the sequence out, sometimes cut short
  task automatic play_episode(input int seq, input int stop_at);
    int span, ticks, cut, k;
    logic [19:0] div;
    span = 0;
    for (k = 0; k < seq_notes[seq]; k++) span += note_ms[seq][k] + note_gap[seq][k];
    div = 20'd1;
    if (span <= 100) div = 20'($urandom_range(3));
    write_tick_div(div);
    ticks = span * ((div == 0) ? 1 : int'(div)) + int'($urandom_range(4));
    cut = ($urandom_range(3) == 0) ? int'($urandom_range(ticks - 1)) : -1;
    send_req(REQ_START, 3'(seq));
    for (k = 0; k < ticks && words_sent < stop_at; k++) begin
      if (k == cut) begin
        if ($urandom_range(1)) send_req(REQ_STOP, 3'($urandom_range(7)));
        else send_req(REQ_START, 3'($urandom_range(7)));
      end else if ($urandom_range(99) < 3) begin
        send_req($urandom_range(1) ? REQ_UNUSED : REQ_START, $urandom_range(1) ? 3'd6 : 3'd7);
      end else begin
        send_req(REQ_TICK, 3'($urandom_range(7)));
      end
    end
  endtask

  task automatic test_random_play(input int sgap, input int rstall, input int budget);
    int first, ep;
    send_gap_pct = sgap;
    recv_stall_pct = rstall;
    first = words_sent;
    ep = $urandom_range(NUM_SEQS - 1);
    while (words_sent - first < budget) begin
      play_episode(ep % NUM_SEQS, first + budget);
      ep++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct = 32;
    recv_stall_pct = 60;
    test_requests();
    test_tick_rates();
    test_random_play(32, 60, 510);
    test_random_play(60, 32, 510);
    test_random_play(0, 0, 510);
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_tones.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_tones.size()));
    $display("Run covered %0d request words and %0d checked results:", words_sent, words_checked);
    $display("  all six sequences, bad ids, stops, restarts, tick dividers 0 to 2^20-1");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tsp_pkg.sv
rtl/tsp_core.sv
rtl/tone_sequence_player.sv
rtl/tsp_checker.sv
dv/testbench.sv
